### src/pfe_pkg.sv
// Shared constants and types for the procedural field evaluator.
// Depends on nothing; the top level and testbench use it by scoped names.

package pfe_pkg;

   // Number of field terms the stores hold, and entries per shaping table.
   localparam int MAX_TERMS   = 8;
   localparam int TABLE_DEPTH = 256;

   // Address and counter widths that follow from the store sizes.
   localparam int TERM_AW     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
   localparam int TABLE_IDX_W = $clog2(TABLE_DEPTH);
   localparam int TABLE_AW    = $clog2(MAX_TERMS * TABLE_DEPTH);
   localparam int CNT_W       = $clog2(MAX_TERMS + 1);

   // Phase arithmetic: 32-bit phase with 24 fractional bits.
   localparam int PHASE_W = 32;
   localparam int FRAC_W  = 24;

   // Accumulator wide enough for MAX_TERMS signed 18-bit term values.
   localparam int TERM_VAL_W = 18;
   localparam int SUM_W      = TERM_VAL_W + CNT_W;

   // Plus one in Q1.12.
   localparam int Q_ONE = 4096;

   // Input transaction kinds carried on req_tuser.
   localparam logic [1:0] CMD_EVAL  = 2'd0;
   localparam logic [1:0] CMD_COEF  = 2'd1;
   localparam logic [1:0] CMD_TABLE = 2'd2;

   // Sequencer states, one-hot.
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_DONE = 3'b100
   } state_type;

endpackage

### src/pfe_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// Depends on nothing; instantiated for the coefficient and table stores.

module pfe_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/procedural_field_evaluator.sv
// Procedural field evaluator top level: sequencer, term pipeline and stores.
// Depends on pfe_pkg and pfe_ram.
//
// Usage. Every transaction on the req_ channel is one command, its kind on
// req_tuser: load a coefficient, load a shaping table entry, or evaluate the
// field at a point. Loads give no response. An evaluation gives exactly one
// transaction on the rsp_ channel: the clamped Q1.12 sum in rsp_tdata and
// the saturation flag in rsp_tuser. The term count is written on the csr_ port
// by the user only while the block is idle; the block does not enforce it.
//
// Timing. An evaluation of n terms issues one term per cycle into a six-stage
// pipeline around the coefficient and table memories. The sequencer issues the
// n terms, waits until the pipeline is empty, then hands the sum over to the
// output register; with no terms it goes straight on to the hand-over. One
// evaluation runs at a time and req_tready is low meanwhile, so a new request
// is only taken once the last evaluation has handed its sum over.
// The response waits in an output register. A new request is accepted while
// it waits; a finished sum that cannot enter the register holds the block.
// Reset clears the sequencer, the term count and the response valid; the
// stores are not cleared and must be loaded before use.

module procedural_field_evaluator (
   input  logic         clock,
   input  logic         reset,
   // Request channel.
   input  logic         req_tvalid,
   output logic         req_tready,
   // Fields from bit 0 up: term_index[2:0], coef_select[4:3],
   // coef_value[36:5], table_index[44:37], table_value[60:45],
   // point_x[72:61], point_y[84:73], point_z[100:85], zero fill[103:101].
   input  logic [103:0] req_tdata,
   // Fields from bit 0 up: command[1:0].
   input  logic [1:0]   req_tuser,
   // Response channel.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // Fields from bit 0 up: field_value[13:0], zero fill[15:14].
   output logic [15:0]  rsp_tdata,
   // Fields from bit 0 up: saturated[0].
   output logic [0:0]   rsp_tuser,
   // Configuration: term_count.
   input  logic         csr_we,
   input  logic [3:0]   csr_wdata
);

   localparam int TERM_AW  = pfe_pkg::TERM_AW;
   localparam int TABLE_AW = pfe_pkg::TABLE_AW;
   localparam int CNT_W    = pfe_pkg::CNT_W;
   localparam int SUM_W    = pfe_pkg::SUM_W;
   localparam int FRAC_W   = pfe_pkg::FRAC_W;
   localparam int TIDX_W   = pfe_pkg::TABLE_IDX_W;

   // Request field decode.
   logic [1:0]  req_command;
   logic [2:0]  req_term_index;
   logic [1:0]  req_coef_select;
   logic [31:0] req_coef_value;
   logic [7:0]  req_table_index;
   logic [15:0] req_table_value;
   logic [11:0] req_point_x;
   logic [11:0] req_point_y;
   logic [15:0] req_point_z;

   assign req_command     = req_tuser;
   assign req_term_index  = req_tdata[2:0];
   assign req_coef_select = req_tdata[4:3];
   assign req_coef_value  = req_tdata[36:5];
   assign req_table_index = req_tdata[44:37];
   assign req_table_value = req_tdata[60:45];
   assign req_point_x     = req_tdata[72:61];
   assign req_point_y     = req_tdata[84:73];
   assign req_point_z     = req_tdata[100:85];

   // Control registers.
   pfe_pkg::state_type state_ff, state_in;
   logic [3:0]         term_count_ff, term_count_in;
   logic [CNT_W-1:0]   issue_ff, issue_in;
   logic [5:0]         pipe_valid_ff, pipe_valid_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   logic [11:0]              x_ff, y_ff;
   logic [15:0]              z_ff;
   logic [TERM_AW-1:0]       term_pipe_ff [4];
   logic [31:0]              xa_ff, yb_ff, c2_ff, d2_ff, d3_ff, s_ff, ph_ff;
   logic [FRAC_W-1:0]        frac_ff;
   logic signed [41:0]       prod_ff;
   logic [15:0]              e0_ff;
   logic signed [SUM_W-1:0]  acc_ff, acc_in;
   logic [13:0]              rsp_value_ff;
   logic                     rsp_sat_ff;

   logic accept;
   assign accept = req_tvalid && req_tready;

   // Active term count, limited to the number of stored terms.
   logic [31:0]      count_wide;
   logic [CNT_W-1:0] term_limit;
   assign count_wide = (32'(term_count_ff) > 32'(pfe_pkg::MAX_TERMS)) ?
                       32'(pfe_pkg::MAX_TERMS) : 32'(term_count_ff);
   assign term_limit = count_wide[CNT_W-1:0];

   logic issue;
   assign issue = (state_ff == pfe_pkg::ST_RUN) && (issue_ff < term_limit);

   // Loads: a term index beyond the stored terms is dropped.
   logic [31:0] load_term;
   logic        load_ok;
   assign load_term = 32'(req_term_index);
   assign load_ok   = load_term < 32'(pfe_pkg::MAX_TERMS);

   logic coef_load, table_load;
   assign coef_load  = accept && (req_command == pfe_pkg::CMD_COEF) && load_ok;
   assign table_load = accept && (req_command == pfe_pkg::CMD_TABLE) && load_ok;

   // Coefficient store: one bank per coefficient so a term's four words are
   // read in parallel. Loads are only taken while the term pipeline is
   // empty, so a write never overlaps a read of the same entry.
   logic [31:0] coef_rd [4];

   for (genvar g = 0; g < 4; g++) begin : g_coef
      pfe_ram #(.WIDTH(32), .DEPTH(pfe_pkg::MAX_TERMS)) u_coef (
         .clock   (clock),
         .wr_en   (coef_load && (req_coef_select == 2'(g))),
         .wr_addr (load_term[TERM_AW-1:0]),
         .wr_data (req_coef_value),
         .rd_addr (issue_ff[TERM_AW-1:0]),
         .rd_data (coef_rd[g])
      );
   end

   // Table store: two identical copies, one read at the lower entry and one
   // at the entry after it.
   logic [TERM_AW+TIDX_W-1:0] tbl_wr_cat, tbl_rd0_cat, tbl_rd1_cat;
   logic [TIDX_W-1:0]         idx0, idx1;
   logic [15:0]               tbl_rd0, tbl_rd1;

   assign idx0        = ph_ff[31:32-TIDX_W];
   assign idx1        = idx0 + TIDX_W'(1);
   assign tbl_wr_cat  = {load_term[TERM_AW-1:0], req_table_index};
   assign tbl_rd0_cat = {term_pipe_ff[3], idx0};
   assign tbl_rd1_cat = {term_pipe_ff[3], idx1};

   pfe_ram #(.WIDTH(16), .DEPTH(pfe_pkg::MAX_TERMS * pfe_pkg::TABLE_DEPTH)) u_table0 (
      .clock   (clock),
      .wr_en   (table_load),
      .wr_addr (tbl_wr_cat[TABLE_AW-1:0]),
      .wr_data (req_table_value),
      .rd_addr (tbl_rd0_cat[TABLE_AW-1:0]),
      .rd_data (tbl_rd0)
   );

   pfe_ram #(.WIDTH(16), .DEPTH(pfe_pkg::MAX_TERMS * pfe_pkg::TABLE_DEPTH)) u_table1 (
      .clock   (clock),
      .wr_en   (table_load),
      .wr_addr (tbl_wr_cat[TABLE_AW-1:0]),
      .wr_data (req_table_value),
      .rd_addr (tbl_rd1_cat[TABLE_AW-1:0]),
      .rd_data (tbl_rd1)
   );

   // Term pipeline datapath. All phase arithmetic wraps at 32 bits.
   logic [31:0] xa_in, yb_in, s_in, ph_in, z_ext;
   assign xa_in = {20'd0, x_ff} * coef_rd[0];
   assign yb_in = {20'd0, y_ff} * coef_rd[1];
   assign s_in  = xa_ff + yb_ff + c2_ff;
   assign z_ext = {{16{z_ff[15]}}, z_ff};
   assign ph_in = s_ff * z_ext + d3_ff;

   // Interpolation: (e1 - e0) * frac, then a floor shift by the fraction width.
   logic signed [16:0] diff;
   logic signed [41:0] prod_in;
   assign diff    = $signed({tbl_rd1[15], tbl_rd1}) - $signed({tbl_rd0[15], tbl_rd0});
   assign prod_in = diff * $signed({1'b0, frac_ff});

   logic signed [17:0]      shifted;
   logic signed [SUM_W-1:0] term_val;
   assign shifted  = prod_ff[41:FRAC_W];
   assign term_val = $signed({{(SUM_W-18){shifted[17]}}, shifted})
                   + $signed({{(SUM_W-16){e0_ff[15]}}, e0_ff});

   // Clamp to plus or minus one.
   logic signed [SUM_W-1:0] q_pos, q_neg;
   logic [13:0]             clamp_value;
   logic                    clamp_sat;
   assign q_pos = SUM_W'(pfe_pkg::Q_ONE);
   assign q_neg = -q_pos;

   always_comb begin
      clamp_value = acc_ff[13:0];
      clamp_sat   = 1'b0;
      if (acc_ff > q_pos) begin
         clamp_value = q_pos[13:0];
         clamp_sat   = 1'b1;
      end else if (acc_ff < q_neg) begin
         clamp_value = q_neg[13:0];
         clamp_sat   = 1'b1;
      end
   end

   // Sequencer.
   logic finish;
   assign finish = (state_ff == pfe_pkg::ST_DONE) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in      = state_ff;
      term_count_in = term_count_ff;
      issue_in      = issue_ff;
      pipe_valid_in = {pipe_valid_ff[4:0], issue};
      rsp_valid_in  = rsp_valid_ff;
      acc_in        = acc_ff;

      if (csr_we) begin
         term_count_in = csr_wdata;
      end
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (pipe_valid_ff[5]) begin
         acc_in = acc_ff + term_val;
      end

      case (state_ff)
         pfe_pkg::ST_IDLE: begin
            if (accept && (req_command == pfe_pkg::CMD_EVAL)) begin
               issue_in = '0;
               acc_in   = '0;
               state_in = pfe_pkg::ST_RUN;
            end
         end
         pfe_pkg::ST_RUN: begin
            if (issue) begin
               issue_in = issue_ff + CNT_W'(1);
            end else if (pipe_valid_ff == '0) begin
               state_in = pfe_pkg::ST_DONE;
            end
         end
         pfe_pkg::ST_DONE: begin
            if (finish) begin
               rsp_valid_in = 1'b1;
               state_in     = pfe_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pfe_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pfe_pkg::ST_IDLE;
         term_count_ff <= '0;
         issue_ff      <= '0;
         pipe_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         term_count_ff <= term_count_in;
         issue_ff      <= issue_in;
         pipe_valid_ff <= pipe_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (accept && (req_command == pfe_pkg::CMD_EVAL)) begin
         x_ff <= req_point_x;
         y_ff <= req_point_y;
         z_ff <= req_point_z;
      end
      term_pipe_ff[0] <= issue_ff[TERM_AW-1:0];
      term_pipe_ff[1] <= term_pipe_ff[0];
      term_pipe_ff[2] <= term_pipe_ff[1];
      term_pipe_ff[3] <= term_pipe_ff[2];
      xa_ff   <= xa_in;
      yb_ff   <= yb_in;
      c2_ff   <= coef_rd[2];
      d2_ff   <= coef_rd[3];
      s_ff    <= s_in;
      d3_ff   <= d2_ff;
      ph_ff   <= ph_in;
      frac_ff <= ph_ff[FRAC_W-1:0];
      prod_ff <= prod_in;
      e0_ff   <= tbl_rd0;
      if (finish) begin
         rsp_value_ff <= clamp_value;
         rsp_sat_ff   <= clamp_sat;
      end
   end

   assign req_tready = (state_ff == pfe_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_value_ff};
   assign rsp_tuser  = rsp_sat_ff;

   // The block only takes requests with the term pipeline empty, which is what
   // keeps loads away from reads in flight.
   a_ready_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (pipe_valid_ff == '0))
      else $error("request accepted with terms still in flight");

   // Terms only reach the accumulator while an evaluation runs.
   a_acc_in_run: assert property (@(posedge clock) disable iff (reset)
      pipe_valid_ff[5] |-> (state_ff == pfe_pkg::ST_RUN))
      else $error("term accumulated outside an evaluation");

   // A response appears only when a finished sum was handed over.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == pfe_pkg::ST_DONE))
      else $error("response raised without a finished evaluation");

   // The issue counter never runs past the active term count.
   a_issue_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pfe_pkg::ST_RUN) |-> (issue_ff <= term_limit))
      else $error("term issue counter overran the term count");

endmodule

### verif/tb.sv
// Self-checking testbench for procedural_field_evaluator: stimulus, prediction and checking.
// Depends on pfe_pkg for store sizes and command codes, and on the block's RTL in src.
`timescale 1ns / 100ps

module tb;

   // The run ends here even if the block hangs; a correct run needs a small
   // fraction of this.
   localparam int LIMIT_CYCLES = 400000;
   // Quiet cycles after the last response before the term count changes or
   // the run ends.
   localparam int DRAIN_CYCLES = 24;
   // Length of the one long response back-pressure episode.
   localparam int HOLD_CYCLES  = 600;
   // Stimulus transactions per random phase.
   localparam int PHASE_ITEMS  = 240;
   localparam int MAX_REPORTS  = 10;
   localparam int STORE_COEFS  = pfe_pkg::MAX_TERMS * 4;
   localparam int STORE_ENTRIES = pfe_pkg::MAX_TERMS * pfe_pkg::TABLE_DEPTH;

   // The one command code the package leaves unnamed; the block ignores it.
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // Coefficient selectors within a term.
   localparam logic [1:0] SEL_X_GAIN = 2'd0;
   localparam logic [1:0] SEL_Y_GAIN = 2'd1;
   localparam logic [1:0] SEL_OFFSET = 2'd2;
   localparam logic [1:0] SEL_PHASE  = 2'd3;

   // One response as the block should produce it.
   typedef struct packed {
      logic [13:0] value;
      logic        sat;
   } field_result_type;

   // All fields of one request transaction, before packing into req_tdata.
   typedef struct {
      logic [2:0]  term;
      logic [1:0]  sel;
      logic [31:0] coef;
      logic [7:0]  tidx;
      logic [15:0] tval;
      logic [11:0] x;
      logic [11:0] y;
      logic [15:0] z;
   } req_fields_type;

   // Shadow of the coefficient and table stores, the term count, and the
   // field sums still owed by the block. Written flags let the stimulus avoid
   // ever reading a store entry that was never loaded.
   class field_checker_type;
      logic [31:0]      coef     [STORE_COEFS];
      bit               coef_ok  [STORE_COEFS];
      logic [15:0]      entry    [STORE_ENTRIES];
      bit               entry_ok [STORE_ENTRIES];
      logic [3:0]       terms = 4'd0;
      field_result_type sums_due [$];
      int               mismatches = 0;

      // A term count beyond the store size is treated as the store size.
      function int active_terms();
         return (terms > pfe_pkg::MAX_TERMS) ? pfe_pkg::MAX_TERMS : int'(terms);
      endfunction

      // Phase of term k: (x*A + y*B + C)*z + D, all in 32-bit wraparound.
      function logic [31:0] phase_of(int k, logic [11:0] x, logic [11:0] y, logic [15:0] z);
         logic [31:0] zw;
         zw = {{16{z[15]}}, z};
         return ({20'd0, x} * coef[k*4] + {20'd0, y} * coef[k*4+1] + coef[k*4+2]) * zw
                + coef[k*4+3];
      endfunction

      // Linear interpolation between the entry picked by the top phase byte
      // and the next one, wrapping from the last entry back to the first.
      // The product is shifted arithmetically, so it rounds toward minus infinity.
      function longint term_value(int k, logic [31:0] ph);
         int         base;
         logic [7:0] i0;
         logic [7:0] i1;
         longint     e0;
         longint     e1;
         longint     frac;
         base = k * pfe_pkg::TABLE_DEPTH;
         i0   = ph[31:24];
         i1   = i0 + 8'd1;
         e0   = $signed(entry[base + int'(i0)]);
         e1   = $signed(entry[base + int'(i1)]);
         frac = ph[23:0];
         return e0 + (((e1 - e0) * frac) >>> 24);
      endfunction

      // Exact sum over the active terms, clamped to plus or minus one in Q1.12.
      // With no active terms the sum is simply zero.
      function field_result_type field_at(logic [11:0] x, logic [11:0] y, logic [15:0] z);
         longint           sum;
         field_result_type r;
         sum = 0;
         for (int k = 0; k < active_terms(); k++) begin
            sum += term_value(k, phase_of(k, x, y, z));
         end
         r.sat = 1'b0;
         if (sum > pfe_pkg::Q_ONE) begin
            sum   = pfe_pkg::Q_ONE;
            r.sat = 1'b1;
         end else if (sum < -pfe_pkg::Q_ONE) begin
            sum   = -pfe_pkg::Q_ONE;
            r.sat = 1'b1;
         end
         r.value = sum[13:0];
         return r;
      endfunction

      // Called for every accepted request transaction.
      function void absorb(logic [1:0] cmd, logic [103:0] d);
         int ci;
         int ti;
         ci = int'(d[2:0]) * 4 + int'(d[4:3]);
         ti = int'(d[2:0]) * pfe_pkg::TABLE_DEPTH + int'(d[44:37]);
         case (cmd)
            pfe_pkg::CMD_COEF: begin
               coef[ci]    = d[36:5];
               coef_ok[ci] = 1'b1;
            end
            pfe_pkg::CMD_TABLE: begin
               entry[ti]    = d[60:45];
               entry_ok[ti] = 1'b1;
            end
            pfe_pkg::CMD_EVAL: begin
               sums_due.push_back(field_at(d[72:61], d[84:73], d[100:85]));
            end
            default: begin
            end
         endcase
      endfunction

      function void flag(string what, int want, int got);
         mismatches++;
         if (mismatches <= MAX_REPORTS) begin
            $display("ERROR: %s expected %0d, got %0d", what, want, got);
         end
      endfunction

      // Called for every accepted response transaction.
      function void match(logic [13:0] value, logic sat);
         field_result_type want;
         if (sums_due.size() == 0) begin
            flag("response with none outstanding, field_value", 0, int'($signed(value)));
            return;
         end
         want = sums_due.pop_front();
         if (want.value !== value) begin
            flag("field_value", int'($signed(want.value)), int'($signed(value)));
         end
         if (want.sat !== sat) begin
            flag("saturated", int'(want.sat), int'(sat));
         end
      endfunction

      function int pending();
         return sums_due.size();
      endfunction
   endclass

   // Clock, reset and all block inputs start at known values.
   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [103:0] req_tdata = '0;
   logic [1:0]   req_tuser = pfe_pkg::CMD_EVAL;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [15:0]  rsp_tdata;
   logic [0:0]   rsp_tuser;
   logic         csr_we = 1'b0;
   logic [3:0]   csr_wdata = 4'd0;

   field_checker_type sb = new;
   int           idle_pct = 36;   // chance in percent that a side idles in a cycle
   bit           hold_request = 1'b0;
   int           hold_left = 0;
   int           items_sent = 0;
   int           cycles = 0;

   always #5 clock = ~clock;

   procedural_field_evaluator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   // Watchdog: a hang anywhere ends the run as a failure.
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Response side. Every accepted response transaction is checked against
   // the oldest outstanding sum. rsp_tready idles at random, except during
   // the one long hold-off, which this process counts down by itself while
   // the sender keeps offering requests so that the block backs up.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.match(rsp_tdata[13:0], rsp_tuser[0]);
      end
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= idle_pct);
      end
   end

   // Field layout of req_tdata, from bit 0 up, zero fill on top.
   function automatic logic [103:0] pack_fields(req_fields_type f);
      return {3'b000, f.z, f.y, f.x, f.tval, f.tidx, f.coef, f.sel, f.term};
   endfunction

   // Fields that a command does not use still carry random content, so the
   // block is seen to ignore them.
   function automatic req_fields_type random_fields();
      req_fields_type f;
      f.term = 3'($urandom);
      f.sel  = 2'($urandom);
      f.coef = $urandom;
      f.tidx = 8'($urandom);
      f.tval = 16'($urandom);
      f.x    = 12'($urandom);
      f.y    = 12'($urandom);
      f.z    = 16'($urandom);
      return f;
   endfunction

   // Coefficients lean toward the extremes, small values, and phase offsets
   // near the top of the range, where the table index wraps.
   function automatic logic [31:0] random_coef();
      case ($urandom_range(9))
         0: return 32'd0;
         1: return 32'h7FFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'($urandom_range(0, 65535)) - 32'd32768;
         4: return {8'hFF, 24'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   // Half of the table entries stay within about plus or minus 0.75 so that
   // unclamped sums are common too.
   function automatic logic [15:0] random_entry();
      if ($urandom_range(1) == 0) begin
         return 16'($urandom);
      end
      return 16'($urandom_range(0, 6000) - 3000);
   endfunction

   function automatic logic [11:0] random_coord();
      case ($urandom_range(9))
         0: return 12'd0;
         1: return 12'hFFF;
         default: return 12'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] random_depth();
      case ($urandom_range(9))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2, 3: return 16'($urandom_range(0, 8) - 4);
         default: return 16'($urandom);
      endcase
   endfunction

   // Offers one request transaction and returns at the edge that accepts it.
   // Random idle cycles go before the offer; valid is only lowered there, so
   // back-to-back transactions keep it high.
   task automatic send(logic [1:0] cmd, req_fields_type f);
      logic [103:0] d;
      d = pack_fields(f);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= d;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      sb.absorb(cmd, d);
      items_sent++;
   endtask

   task automatic load_coef(int k, logic [1:0] sel, logic [31:0] v);
      req_fields_type f;
      f      = random_fields();
      f.term = 3'(k);
      f.sel  = sel;
      f.coef = v;
      send(pfe_pkg::CMD_COEF, f);
   endtask

   task automatic load_entry(int k, int idx, logic [15:0] v);
      req_fields_type f;
      f      = random_fields();
      f.term = 3'(k);
      f.tidx = 8'(idx);
      f.tval = v;
      send(pfe_pkg::CMD_TABLE, f);
   endtask

   // Evaluates a point. Any coefficient of an active term, and any table
   // entry this point will read, that has never been loaded is loaded with a
   // random value first, so the block never reads an unwritten entry.
   task automatic eval_point(logic [11:0] x, logic [11:0] y, logic [15:0] z);
      req_fields_type f;
      logic [31:0]    ph;
      int             base;
      int             i0;
      int             i1;
      for (int k = 0; k < sb.active_terms(); k++) begin
         for (int s = 0; s < 4; s++) begin
            if (!sb.coef_ok[k*4 + s]) begin
               load_coef(k, 2'(s), random_coef());
            end
         end
      end
      for (int k = 0; k < sb.active_terms(); k++) begin
         ph   = sb.phase_of(k, x, y, z);
         base = k * pfe_pkg::TABLE_DEPTH;
         i0   = int'(ph[31:24]);
         i1   = (i0 + 1) % pfe_pkg::TABLE_DEPTH;
         if (!sb.entry_ok[base + i0]) begin
            load_entry(k, i0, random_entry());
         end
         if (!sb.entry_ok[base + i1]) begin
            load_entry(k, i1, random_entry());
         end
      end
      f   = random_fields();
      f.x = x;
      f.y = y;
      f.z = z;
      send(pfe_pkg::CMD_EVAL, f);
   endtask

   // The term count is only changed with the block idle: every outstanding
   // response has arrived and the last load has had time to settle.
   task automatic program_terms(logic [3:0] n);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= n;
      @(posedge clock);
      csr_we    <= 1'b0;
      sb.terms = n;
   endtask

   // Term counts of the random phases: the full store, small counts, and
   // counts above the store size, which the block treats as the store size.
   logic [3:0] phase_terms [8] = '{4'd8, 4'd2, 4'd15, 4'd1, 4'd5, 4'd12, 4'd3, 4'd8};

   initial begin
      req_fields_type f;
      int             target;
      int             start;
      int             r;
      bit             held;

      held = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, one active term.
      program_terms(4'd1);

      // The unused command with every field bit set must be ignored.
      f      = random_fields();
      f.term = '1;
      f.sel  = '1;
      f.coef = '1;
      f.tidx = '1;
      f.tval = '1;
      f.x    = '1;
      f.y    = '1;
      f.z    = '1;
      send(CMD_UNUSED, f);

      // Zero gains and offset leave the phase equal to the phase offset, so
      // the point does not matter. Phase 0xFF80_0000 reads the last entry,
      // wraps to the first, and interpolates halfway between the two table
      // extremes: 32767 - 32767.5 rounds down to -1.
      load_coef(0, SEL_X_GAIN, 32'd0);
      load_coef(0, SEL_Y_GAIN, 32'd0);
      load_coef(0, SEL_OFFSET, 32'd0);
      load_coef(0, SEL_PHASE, 32'hFF80_0000);
      load_entry(0, 255, 16'h7FFF);
      load_entry(0, 0, 16'h8000);
      eval_point(12'hFFF, 12'hFFF, 16'h8000);
      eval_point(12'd0, 12'd0, 16'h7FFF);

      // No fraction: the value is the last entry itself, clamped high, and
      // then clamped low once that entry is the most negative.
      load_coef(0, SEL_PHASE, 32'hFF00_0000);
      eval_point(12'd17, 12'd4000, 16'd3);
      load_entry(0, 255, 16'h8000);
      eval_point(12'd4000, 12'd17, 16'hFFFD);

      // Extreme gains with the point at the corners of its range.
      load_coef(0, SEL_X_GAIN, 32'h8000_0000);
      load_coef(0, SEL_Y_GAIN, 32'h7FFF_FFFF);
      load_coef(0, SEL_OFFSET, 32'h0100_0000);
      eval_point(12'hFFF, 12'd0, 16'd1);
      eval_point(12'd0, 12'hFFF, 16'hFFFF);
      eval_point(12'hFFF, 12'hFFF, 16'h7FFF);

      // No active terms: the sum is zero and never saturated.
      program_terms(4'd0);
      eval_point(12'd123, 12'd456, 16'd789);
      eval_point(12'hFFF, 12'hFFF, 16'h8000);

      // Random phases. Most transactions are evaluations; loads keep
      // changing the stores under them.
      for (int p = 0; p < 8; p++) begin
         program_terms(phase_terms[p]);
         // The third phase runs with neither side ever idling.
         idle_pct = (p == 2) ? 0 : 36;
         start    = items_sent;
         target   = items_sent + PHASE_ITEMS;
         while (items_sent < target) begin
            if (p == 4 && !held && items_sent - start >= 60) begin
               hold_request = 1'b1;
               held         = 1'b1;
            end
            r = $urandom_range(99);
            if (r < 55) begin
               eval_point(random_coord(), random_coord(), random_depth());
            end else if (r < 75) begin
               load_coef($urandom_range(7), 2'($urandom), random_coef());
            end else if (r < 93) begin
               load_entry($urandom_range(7), $urandom_range(255), random_entry());
            end else begin
               send(CMD_UNUSED, random_fields());
            end
         end
      end

      // Drain: every sum must arrive, then nothing further may follow.
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
